// ----- design/c2d_pkg.sv -----
package c2d_pkg;

  localparam int unsigned LINE_DEPTH = 2560;
  localparam int unsigned LINE_AW    = 12;
  localparam int unsigned WT_DEPTH   = 1600;
  localparam int unsigned WT_AW      = 11;
  localparam int unsigned NUM_UNITS  = 8;
  localparam int unsigned NUM_SLOTS  = 5;

  localparam logic [1:0] OP_WEIGHT = 2'd0;
  localparam logic [1:0] OP_BIAS   = 2'd1;
  localparam logic [1:0] OP_SAMPLE = 2'd2;

  localparam logic [2:0] REG_WIDTH   = 3'd0;
  localparam logic [2:0] REG_HEIGHT  = 3'd1;
  localparam logic [2:0] REG_CHANS   = 3'd2;
  localparam logic [2:0] REG_KH      = 3'd3;
  localparam logic [2:0] REG_KW      = 3'd4;
  localparam logic [2:0] REG_UNITS   = 3'd5;
  localparam logic [2:0] REG_BIAS_EN = 3'd6;

  // control that travels with one tap through the MAC pipeline
  typedef struct packed {
    logic clear;
    logic vld;
    logic last;
  } mac_ctl_t;

endpackage

// ----- design/c2d_ram.sv -----
module c2d_ram #(
  parameter int unsigned DEPTH = 1600,
  parameter int unsigned AW    = 11
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic signed [15:0] wdata_i,
  input  logic [AW-1:0]     raddr_i,
  output logic signed [15:0] rdata_o
);

  logic signed [15:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- design/c2d_mac.sv -----
module c2d_mac (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  c2d_pkg::mac_ctl_t       ctl_i,
  input  logic signed [15:0]      sample_i,
  input  logic signed [15:0]      weight_i,
  input  logic signed [15:0]      bias_i,
  input  logic                    bias_en_i,
  output logic                    done_o,
  output logic signed [39:0]      result_o
);
  import c2d_pkg::*;

  localparam logic signed [41:0] SatHi = 42'sh007FFFFFFFFF;
  localparam logic signed [41:0] SatLo = -42'sh008000000000;

  logic signed [31:0] prod_q;
  logic               p_vld_q;
  logic               p_last_q;
  logic signed [40:0] acc_q;
  logic signed [41:0] bias_term;
  logic signed [41:0] sum;

  always_ff @(posedge clk_i) begin
    prod_q <= sample_i * weight_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q  <= 1'b0;
      p_last_q <= 1'b0;
      done_o   <= 1'b0;
      acc_q    <= '0;
    end else begin
      p_vld_q  <= ctl_i.vld;
      p_last_q <= ctl_i.vld & ctl_i.last;
      done_o   <= p_vld_q & p_last_q;
      if (ctl_i.clear) begin
        acc_q <= '0;
      end else if (p_vld_q) begin
        acc_q <= acc_q + 41'(prod_q);
      end
    end
  end

  // bias is Q8.8, move it to the .16 point of the sum
  assign bias_term = bias_en_i ? {{18{bias_i[15]}}, bias_i, 8'd0} : '0;
  assign sum       = 42'(acc_q) + bias_term;

  always_comb begin
    if (sum > SatHi) begin
      result_o = SatHi[39:0];
    end else if (sum < SatLo) begin
      result_o = SatLo[39:0];
    end else begin
      result_o = sum[39:0];
    end
  end

endmodule

// ----- design/conv2d_valid_stride1_stream.sv -----
// Channel    Dir  Handshake               Payload
// s_axis     in   tvalid/tready           tuser: opcode; tdata: table_index, sample_value
// m_axis     out  tvalid/tready           tdata: row, col, unit, value; tlast: last_unit
// cfg        in   cfg_we_i (no ready)     cfg_addr_i register index, cfg_wdata_i value
//
// Weight and bias loads, and samples that complete no window, leave the block idle.
// A sample that completes a window starts a pass of KH*KW*CH taps for each unit:
// one tap per cycle is read from the line and weight memories into a single MAC.
// Input is accepted only between windows; a result waits in the output register
// while the next unit computes, and the MAC holds when that register is full.
// Reset clears counters and control; the memories and bias store are not cleared.
module conv2d_valid_stride1_stream (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // table_index[10:0], sample_value[26:11]
  input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // out_row[9:0], out_col[15:10], out_unit[18:16],
                                      // out_value[58:19]
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [10:0] cfg_wdata_i
);
  import c2d_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT,
    ST_FIN
  } state_e;

  // configuration registers, raw
  logic [6:0]  width_q;
  logic [10:0] height_q;
  logic [3:0]  chans_q;
  logic [2:0]  kh_q;
  logic [2:0]  kw_q;
  logic [3:0]  units_q;
  logic        bias_en_q;

  // clamped values
  logic [6:0]  w_c;
  logic [10:0] h_c;
  logic [3:0]  nch_c;
  logic [2:0]  kh_c;
  logic [2:0]  kw_c;
  logic [3:0]  nu_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= 7'd32;
      height_q  <= 11'd32;
      chans_q   <= 4'd3;
      kh_q      <= 3'd3;
      kw_q      <= 3'd3;
      units_q   <= 4'd8;
      bias_en_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_WIDTH:   width_q   <= cfg_wdata_i[6:0];
        REG_HEIGHT:  height_q  <= cfg_wdata_i;
        REG_CHANS:   chans_q   <= cfg_wdata_i[3:0];
        REG_KH:      kh_q      <= cfg_wdata_i[2:0];
        REG_KW:      kw_q      <= cfg_wdata_i[2:0];
        REG_UNITS:   units_q   <= cfg_wdata_i[3:0];
        REG_BIAS_EN: bias_en_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w_c   = (width_q == '0) ? 7'd1 : (width_q > 7'd64) ? 7'd64 : width_q;
    h_c   = (height_q == '0) ? 11'd1 : (height_q > 11'd1024) ? 11'd1024 : height_q;
    nch_c = (chans_q == '0) ? 4'd1 : (chans_q > 4'd8) ? 4'd8 : chans_q;
    kh_c  = (kh_q == '0) ? 3'd1 : (kh_q > 3'd5) ? 3'd5 : kh_q;
    kw_c  = (kw_q == '0) ? 3'd1 : (kw_q > 3'd5) ? 3'd5 : kw_q;
    nu_c  = (units_q == '0) ? 4'd1 : (units_q > 4'd8) ? 4'd8 : units_q;
  end

  // input item fields
  logic [1:0]         in_op;
  logic [10:0]        in_idx;
  logic signed [15:0] in_val;
  logic               in_acc;

  assign in_op  = s_axis_tuser;
  assign in_idx = s_axis_tdata[10:0];
  assign in_val = s_axis_tdata[26:11];

  state_e state_q;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;

  // stream position; slot_q tracks row_q modulo the slot count
  logic [9:0] row_q;
  logic [5:0] col_q;
  logic [2:0] chan_q;
  logic [2:0] slot_q;

  // window and tap walk
  logic [9:0]  r0_q;
  logic [5:0]  c0_q;
  logic [2:0]  slot0_q;
  logic [2:0]  u_q;
  logic [2:0]  kr_q, kc_q, tc_q, rs_q;
  logic [5:0]  cc_q;
  logic [10:0] wi_q;

  // bias store
  logic signed [15:0] bias_q [NUM_UNITS];

  // sample-side decisions
  logic        is_sample;
  logic        chan_last;
  logic        emit;
  logic [3:0]  chan_nx;
  logic [6:0]  col_nx;
  logic [10:0] row_nx;
  logic [3:0]  slot_base;
  logic [2:0]  slot_start;

  assign is_sample = in_acc & (in_op == OP_SAMPLE);
  assign chan_nx   = {1'b0, chan_q} + 4'd1;
  assign col_nx    = {1'b0, col_q} + 7'd1;
  assign row_nx    = {1'b0, row_q} + 11'd1;
  assign chan_last = (chan_nx == nch_c);
  assign emit      = chan_last & (row_nx >= {8'd0, kh_c}) & (col_nx >= {4'd0, kw_c});
  // first window row slot: (slot + 1 - kh) mod 5
  assign slot_base  = {1'b0, slot_q} + 4'd6 - {1'b0, kh_c};
  assign slot_start = (slot_base >= 4'(NUM_SLOTS)) ? 3'(slot_base - 4'(NUM_SLOTS))
                                                   : slot_base[2:0];

  // tap walk decisions
  logic tc_end, kc_end, kr_end, last_tap, unit_last, out_free;

  assign tc_end    = ({1'b0, tc_q} + 4'd1 == nch_c);
  assign kc_end    = (kc_q + 3'd1 == kw_c);
  assign kr_end    = (kr_q + 3'd1 == kh_c);
  assign last_tap  = tc_end & kc_end & kr_end;
  assign unit_last = ({1'b0, u_q} + 4'd1 == nu_c);
  assign out_free  = ~m_axis_tvalid | m_axis_tready;

  // memories
  logic [LINE_AW-1:0]  line_waddr, line_raddr;
  logic signed [15:0]  line_rdata, wt_rdata;
  logic                wt_we;

  assign line_waddr = {slot_q, col_q, chan_q};
  assign line_raddr = {rs_q, cc_q, tc_q};
  assign wt_we      = in_acc & (in_op == OP_WEIGHT) & (in_idx < 11'(WT_DEPTH));

  c2d_ram #(.DEPTH(LINE_DEPTH), .AW(LINE_AW)) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (is_sample),
    .waddr_i (line_waddr),
    .wdata_i (in_val),
    .raddr_i (line_raddr),
    .rdata_o (line_rdata)
  );

  c2d_ram #(.DEPTH(WT_DEPTH), .AW(WT_AW)) u_wt_ram (
    .clk_i   (clk_i),
    .we_i    (wt_we),
    .waddr_i (in_idx),
    .wdata_i (in_val),
    .raddr_i (wi_q),
    .rdata_o (wt_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (in_acc && (in_op == OP_BIAS) && (in_idx < 11'(NUM_UNITS))) begin
      bias_q[in_idx[2:0]] <= in_val;
    end
  end

  // MAC: tag trails the issue in the next cycle, aligned with read data
  mac_ctl_t           mac_ctl;
  logic               t1_vld_q, t1_last_q;
  logic               mac_done;
  logic signed [39:0] mac_res;
  logic               issue;
  logic               start_win;
  logic               next_unit;
  logic               out_load;

  assign issue     = (state_q == ST_RUN);
  assign start_win = is_sample & emit;
  assign next_unit = (state_q == ST_FIN) & out_free & ~unit_last;
  // load the output register with the finished unit
  assign out_load  = (state_q == ST_FIN) & out_free;

  always_comb begin
    mac_ctl.clear = start_win | next_unit;
    mac_ctl.vld   = t1_vld_q;
    mac_ctl.last  = t1_last_q;
  end

  c2d_mac u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (mac_ctl),
    .sample_i  (line_rdata),
    .weight_i  (wt_rdata),
    .bias_i    (bias_q[u_q]),
    .bias_en_i (bias_en_q),
    .done_o    (mac_done),
    .result_o  (mac_res)
  );

  // output register
  logic [9:0]  o_row_q;
  logic [5:0]  o_col_q;
  logic [2:0]  o_unit_q;
  logic [39:0] o_val_q;
  logic        o_last_q;
  logic        o_vld_q;

  assign m_axis_tvalid = o_vld_q;
  assign m_axis_tdata  = {5'd0, o_val_q, o_unit_q, o_col_q, o_row_q};
  assign m_axis_tlast  = o_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      row_q     <= '0;
      col_q     <= '0;
      chan_q    <= '0;
      slot_q    <= '0;
      r0_q      <= '0;
      c0_q      <= '0;
      slot0_q   <= '0;
      u_q       <= '0;
      kr_q      <= '0;
      kc_q      <= '0;
      tc_q      <= '0;
      rs_q      <= '0;
      cc_q      <= '0;
      wi_q      <= '0;
      t1_vld_q  <= 1'b0;
      t1_last_q <= 1'b0;
      o_vld_q   <= 1'b0;
      o_row_q   <= '0;
      o_col_q   <= '0;
      o_unit_q  <= '0;
      o_val_q   <= '0;
      o_last_q  <= 1'b0;
    end else begin
      t1_vld_q  <= issue;
      t1_last_q <= issue & last_tap;
      if (out_load) begin
        o_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        o_vld_q <= 1'b0;
      end

      // advance the stream position on every sample
      if (is_sample) begin
        if (chan_nx >= nch_c) begin
          chan_q <= '0;
          if (col_nx >= w_c) begin
            col_q <= '0;
            if (row_nx >= h_c) begin
              row_q  <= '0;
              slot_q <= '0;
            end else begin
              row_q  <= row_nx[9:0];
              slot_q <= (slot_q == 3'(NUM_SLOTS - 1)) ? 3'd0 : slot_q + 3'd1;
            end
          end else begin
            col_q <= col_nx[5:0];
          end
        end else begin
          chan_q <= chan_nx[2:0];
        end
      end

      case (state_q)
        ST_IDLE: begin
          if (start_win) begin
            r0_q    <= row_nx[9:0] - {7'd0, kh_c};
            c0_q    <= col_nx[5:0] - {3'd0, kw_c};
            cc_q    <= col_nx[5:0] - {3'd0, kw_c};
            slot0_q <= slot_start;
            rs_q    <= slot_start;
            u_q     <= '0;
            kr_q    <= '0;
            kc_q    <= '0;
            tc_q    <= '0;
            wi_q    <= '0;
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          // one tap per cycle: channel fastest, then column, then row
          wi_q <= wi_q + {7'd0, nu_c};
          if (tc_end) begin
            tc_q <= '0;
            if (kc_end) begin
              kc_q <= '0;
              cc_q <= c0_q;
              kr_q <= kr_q + 3'd1;
              rs_q <= (rs_q == 3'(NUM_SLOTS - 1)) ? 3'd0 : rs_q + 3'd1;
            end else begin
              kc_q <= kc_q + 3'd1;
              cc_q <= cc_q + 6'd1;
            end
          end else begin
            tc_q <= tc_q + 3'd1;
          end
          if (last_tap) begin
            state_q <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (mac_done) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            o_row_q  <= r0_q;
            o_col_q  <= c0_q;
            o_unit_q <= u_q;
            o_val_q  <= mac_res;
            o_last_q <= unit_last;
            if (unit_last) begin
              state_q <= ST_IDLE;
            end else begin
              u_q     <= u_q + 3'd1;
              wi_q    <= {8'd0, u_q} + 11'd1;
              kr_q    <= '0;
              kc_q    <= '0;
              tc_q    <= '0;
              cc_q    <= c0_q;
              rs_q    <= slot0_q;
              state_q <= ST_RUN;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
